>>> sv/apdc_pkg.sv
`timescale 1ns / 1ps

package apdc_pkg;

  // Full-scale duty code and the width of the duty datapath
  localparam int unsigned DutyW    = 10;
  localparam logic [DutyW-1:0] DutyFull = 10'd1023;

  // Quotient bits resolved by the divider pipe, one per stage
  localparam int unsigned DivBits  = DutyW;

  // Field widths
  localparam int unsigned CmdW     = 16;
  localparam int unsigned BattW    = 16;
  localparam int unsigned DsrW     = BattW - 1;
  localparam int unsigned NumW     = CmdW + 8 + 3;
  localparam int unsigned ScaleW   = 16;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CfgCompMode  = 3'd0,
    CfgRefVolt   = 3'd1,
    CfgBattMin   = 3'd2,
    CfgBattMax   = 3'd3,
    CfgDutyMin   = 3'd4,
    CfgDutyMax   = 3'd5,
    CfgInvert    = 3'd6,
    CfgPwmScale  = 3'd7
  } cfg_reg_e;

  // Per-item control that rides alongside the divider
  typedef struct packed {
    logic             enable;
    logic             ign;
    logic             inh;
    logic             linear;
    logic             force_full;
    logic             force_zero;
    logic [DutyW-1:0] lim_cmd;
  } ctl_t;

  // Restoring-division working state
  typedef struct packed {
    logic [NumW-1:0]    rem;
    logic [DsrW-1:0]    dsr;
    logic [DivBits-1:0] quo;
  } div_t;

endpackage

>>> sv/actuator_pwm_duty_conditioner_unit.sv
`timescale 1ns / 1ps

// Actuator PWM duty conditioner.
// Input channel: pulse start_i with a control tick on req_cmd_i, batt_voltage_i,
// ignition_on_i and cmd_inhibit_i; the tick is taken at any edge where start_i
// is high and busy_o is low. busy_o never rises, so a tick may enter every cycle.
// Result channel: res_valid_o is high for one cycle with comp_cmd_o,
// drive_enable_o, dormant_o, applied_duty_o and pwm_value_o. The receiver
// cannot hold results off and none is needed: nothing stalls inside.
// Pipeline: a tick passes the input, product and range check stages, then the
// divider pipe that resolves one quotient bit per stage (10 stages), then the
// limit and PWM multiply stages.
// Throughput: one tick per cycle.
// Configuration: cfg_valid_i / cfg_ready_o with cfg_index_i and cfg_data_i;
// cfg_ready_o is always high. Write only while no tick is in flight.
// Reset: rst_ni clears all valid bits and returns the registers to their
// defaults (duty_max 255, pwm_scale 1, the rest zero); no clearing pass.
module actuator_pwm_duty_conditioner_unit (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // tick input
  input  logic                                 start_i,
  output logic                                 busy_o,
  input  logic [apdc_pkg::CmdW-1:0]            req_cmd_i,
  input  logic signed [apdc_pkg::BattW-1:0]    batt_voltage_i,
  input  logic                                 ignition_on_i,
  input  logic                                 cmd_inhibit_i,
  // result output
  output logic                                 res_valid_o,
  output logic [apdc_pkg::DutyW-1:0]           comp_cmd_o,
  output logic                                 drive_enable_o,
  output logic                                 dormant_o,
  output logic [apdc_pkg::DutyW-1:0]           applied_duty_o,
  output logic [apdc_pkg::ScaleW-1:0]          pwm_value_o,
  // configuration write
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  apdc_pkg::cfg_reg_e                   cfg_index_i,
  input  logic [apdc_pkg::CfgDataW-1:0]        cfg_data_i
);

  import apdc_pkg::*;

  localparam int unsigned Latency = DivBits + 5;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic              comp_mode_q;
  logic [7:0]        ref_volt_q;
  logic [7:0]        batt_min_q;
  logic [7:0]        batt_max_q;
  logic [7:0]        duty_min_q;
  logic [7:0]        duty_max_q;
  logic              invert_q;
  logic [ScaleW-1:0] pwm_scale_q;

  assign cfg_ready_o = 1'b1;
  assign busy_o      = 1'b0;

  // Take a configuration transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      comp_mode_q <= 1'b0;
      ref_volt_q  <= 8'd0;
      batt_min_q  <= 8'd0;
      batt_max_q  <= 8'd0;
      duty_min_q  <= 8'd0;
      duty_max_q  <= 8'd255;
      invert_q    <= 1'b0;
      pwm_scale_q <= 16'd1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CfgCompMode: comp_mode_q <= cfg_data_i[0];
        CfgRefVolt:  ref_volt_q  <= cfg_data_i[7:0];
        CfgBattMin:  batt_min_q  <= cfg_data_i[7:0];
        CfgBattMax:  batt_max_q  <= cfg_data_i[7:0];
        CfgDutyMin:  duty_min_q  <= cfg_data_i[7:0];
        CfgDutyMax:  duty_max_q  <= cfg_data_i[7:0];
        CfgInvert:   invert_q    <= cfg_data_i[0];
        CfgPwmScale: pwm_scale_q <= cfg_data_i[ScaleW-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: input register
  // ---------------------------------------------------------------------------
  logic                    s1_vld_q;
  logic [CmdW-1:0]         s1_cmd_q;
  logic signed [BattW-1:0] s1_batt_q;
  logic                    s1_ign_q;
  logic                    s1_inh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= start_i && !busy_o;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_cmd_q  <= req_cmd_i;
    s1_batt_q <= batt_voltage_i;
    s1_ign_q  <= ignition_on_i;
    s1_inh_q  <= cmd_inhibit_i;
  end

  // ---------------------------------------------------------------------------
  // Stage 2: numerator product, battery window, plain limit
  // ---------------------------------------------------------------------------
  logic                    s2_vld_q;
  logic [NumW-1:0]         s2_num_q, s2_num_d;
  logic [CmdW+7:0]         s2_prod;
  logic [BattW-1:0]        s2_batt_q;
  ctl_t                    s2_ctl_q, s2_ctl_d;
  logic signed [BattW-1:0] win_lo, win_hi;

  always_comb begin
    win_lo   = $signed({5'd0, batt_min_q, 3'd0});
    win_hi   = $signed({5'd0, batt_max_q, 3'd0});
    // Full-width product of command and reference, then times eight
    s2_prod  = (CmdW+8)'(s1_cmd_q) * (CmdW+8)'(ref_volt_q);
    s2_num_d = {s2_prod, 3'd0};
    s2_ctl_d.enable     = (s1_batt_q > win_lo) && (s1_batt_q < win_hi);
    s2_ctl_d.ign        = s1_ign_q;
    s2_ctl_d.inh        = s1_inh_q;
    s2_ctl_d.linear     = comp_mode_q;
    s2_ctl_d.force_full = (s1_batt_q == '0);
    s2_ctl_d.force_zero = s1_batt_q[BattW-1];
    s2_ctl_d.lim_cmd    = (|s1_cmd_q[CmdW-1:DutyW]) ? DutyFull : s1_cmd_q[DutyW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else begin
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_num_q  <= s2_num_d;
    s2_batt_q <= s1_batt_q;
    s2_ctl_q  <= s2_ctl_d;
  end

  // ---------------------------------------------------------------------------
  // Stage 3: saturation check, load the divider
  // ---------------------------------------------------------------------------
  logic   dv_vld_q [DivBits+1];
  div_t   dv_q     [DivBits+1];
  ctl_t   dv_ctl_q [DivBits+1];
  div_t   dv_in_d;
  ctl_t   dv_in_ctl_d;
  logic [NumW-1:0] sat_lim;

  always_comb begin
    sat_lim        = NumW'({s2_batt_q[DsrW-1:0], {DivBits{1'b0}}});
    dv_in_d.rem    = s2_num_q;
    dv_in_d.dsr    = s2_batt_q[DsrW-1:0];
    dv_in_d.quo    = '0;
    dv_in_ctl_d    = s2_ctl_q;
    // Quotient of 1024 or more saturates to full scale
    if (s2_num_q >= sat_lim) begin
      dv_in_ctl_d.force_full = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_vld_q[0] <= 1'b0;
    end else begin
      dv_vld_q[0] <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    dv_q[0]     <= dv_in_d;
    dv_ctl_q[0] <= dv_in_ctl_d;
  end

  // ---------------------------------------------------------------------------
  // Stages 4..13: restoring division, one quotient bit per stage, MSB first
  // ---------------------------------------------------------------------------
  for (genvar i = 0; i < DivBits; i++) begin : g_div
    localparam int unsigned Bit = DivBits - 1 - i;
    div_t            st_d;
    logic [NumW-1:0] trial;

    always_comb begin
      trial = NumW'(dv_q[i].dsr) << Bit;
      st_d  = dv_q[i];
      if (dv_q[i].rem >= trial) begin
        st_d.rem      = dv_q[i].rem - trial;
        st_d.quo[Bit] = 1'b1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_vld_q[i+1] <= 1'b0;
      end else begin
        dv_vld_q[i+1] <= dv_vld_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      dv_q[i+1]     <= st_d;
      dv_ctl_q[i+1] <= dv_ctl_q[i];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 14: pick the command, clamp to the duty range, invert
  // ---------------------------------------------------------------------------
  ctl_t             fin_ctl;
  logic [DutyW-1:0] comp_d, duty_lo, duty, applied_d;
  logic [DutyW-1:0] lo_lim, hi_lim;
  logic             s14_vld_q;
  logic [DutyW-1:0] s14_comp_q, s14_applied_q;
  logic             s14_en_q, s14_gate_q;

  always_comb begin
    fin_ctl = dv_ctl_q[DivBits];
    lo_lim  = {duty_min_q, 2'b00};
    hi_lim  = {duty_max_q, 2'b00};
    // Select compensated or plainly limited command
    if (!fin_ctl.linear) begin
      comp_d = fin_ctl.lim_cmd;
    end else if (fin_ctl.force_zero) begin
      comp_d = '0;
    end else if (fin_ctl.force_full) begin
      comp_d = DutyFull;
    end else begin
      comp_d = dv_q[DivBits].quo;
    end
    // Clamp lower bound first, upper bound last
    duty_lo = (comp_d < lo_lim) ? lo_lim : comp_d;
    if (comp_d != '0 && fin_ctl.enable) begin
      duty = (duty_lo > hi_lim) ? hi_lim : duty_lo;
    end else begin
      duty = '0;
    end
    // Invert: zero duty maps to full scale, else 1024 minus duty
    if (!invert_q) begin
      applied_d = duty;
    end else if (duty == '0) begin
      applied_d = DutyFull;
    end else begin
      applied_d = DutyW'(~duty + 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s14_vld_q <= 1'b0;
    end else begin
      s14_vld_q <= dv_vld_q[DivBits];
    end
  end

  always_ff @(posedge clk_i) begin
    s14_comp_q    <= comp_d;
    s14_applied_q <= applied_d;
    s14_en_q      <= fin_ctl.enable;
    s14_gate_q    <= fin_ctl.ign && !fin_ctl.inh;
  end

  // ---------------------------------------------------------------------------
  // Stage 15: PWM scaling and result register
  // ---------------------------------------------------------------------------
  logic [DutyW+ScaleW-1:0] pwm_prod;
  logic                    res_vld_q;
  logic [DutyW-1:0]        res_comp_q, res_applied_q;
  logic                    res_en_q, res_dormant_q;
  logic [ScaleW-1:0]       res_pwm_q, res_pwm_d;

  always_comb begin
    pwm_prod  = s14_applied_q * pwm_scale_q;
    res_pwm_d = s14_gate_q ? pwm_prod[ScaleW-1:0] : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else begin
      res_vld_q <= s14_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    res_comp_q    <= s14_comp_q;
    res_applied_q <= s14_applied_q;
    res_en_q      <= s14_en_q;
    res_dormant_q <= (s14_comp_q == '0);
    res_pwm_q     <= res_pwm_d;
  end

  assign res_valid_o    = res_vld_q;
  assign comp_cmd_o     = res_comp_q;
  assign drive_enable_o = res_en_q;
  assign dormant_o      = res_dormant_q;
  assign applied_duty_o = res_applied_q;
  assign pwm_value_o    = res_pwm_q;

`ifndef SYNTHESIS
  // Every accepted tick yields its result at the end of the pipeline
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##Latency res_valid_o)
    else $error("accepted tick produced no result at the expected cycle");

  // No result without a tick accepted at the matching cycle
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> $past(start_i && !busy_o, Latency))
    else $error("result without a matching accepted tick");

  // Inactive command gives either zero or full-scale (inverted) duty
  a_inactive_duty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && (dormant_o || !drive_enable_o) && applied_duty_o != DutyFull)
      |-> applied_duty_o == '0)
    else $error("inactive command produced a nonzero clamped duty");
`endif

endmodule
